### hdl/ham_pkg.sv
// Shared types and codes for the hashed address map.
package ham_pkg;

  // Transaction command codes
  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_LOOKUP   = 1'b1
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MISS = 2'd0,
    ST_HIT  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RED,
    S_RD,
    S_EXE
  } state_t;

  // One way of a bucket row
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] pub;
    logic [15:0] id;
  } entry_t;

endpackage

### hdl/hashed_address_map_top.sv
// Hashed address map: set-associative table from private to public address.
// Sequence: an accepted transaction steps through hash sum, bucket reduce, row read,
//   and compare and write back (S_IDLE, S_RED, S_RD, S_EXE); S_EXE loads out_valid and
//   waits while a held result is not taken. A new transaction is accepted only in S_IDLE.
// Reset: after rst the block sweeps BUCKETS rows, one per cycle, clearing the
//   valid bits; in_ready stays low until the sweep is done.
module hashed_address_map_top
  import ham_pkg::*;
#(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] private_addr,
  input  logic [31:0] public_addr,
  input  logic [15:0] echo_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] found_public,
  output logic [15:0] found_id
);

  localparam int BW = $clog2(BUCKETS);
  localparam int SW = BW + 7;

  // Residues of 16**i mod BUCKETS, one per key nibble
  localparam int unsigned R0 = 1 % BUCKETS;
  localparam int unsigned R1 = (R0 * 16) % BUCKETS;
  localparam int unsigned R2 = (R1 * 16) % BUCKETS;
  localparam int unsigned R3 = (R2 * 16) % BUCKETS;
  localparam int unsigned R4 = (R3 * 16) % BUCKETS;
  localparam int unsigned R5 = (R4 * 16) % BUCKETS;
  localparam int unsigned R6 = (R5 * 16) % BUCKETS;
  localparam int unsigned R7 = (R6 * 16) % BUCKETS;
  localparam int unsigned RES [8] = '{R0, R1, R2, R3, R4, R5, R6, R7};

  typedef entry_t [WAYS-1:0] row_t;

  state_t          state, state_next;
  logic [BW-1:0]   clr_idx;
  cmd_t            cmd_r;
  logic [31:0]     key_r;
  logic [31:0]     public_r;
  logic [15:0]     id_r;
  logic [SW-1:0]   sum, sum_next;
  logic [BW-1:0]   bucket, bucket_next;
  row_t            mem [BUCKETS];
  row_t            rd_row;
  row_t            wr_row;
  row_t            mem_wdata;
  logic [BW-1:0]   mem_waddr;
  logic            mem_we, mem_re, load_out;
  status_t         res_status, res_status_next;
  logic [31:0]     res_public, res_public_next;
  logic [15:0]     res_id, res_id_next;
  logic [WAYS-1:0] hit_oh, free_oh;
  logic            any_hit, any_free;
  entry_t          hit_entry;
  logic            accept;

  assign accept = in_valid && in_ready;

  // Nibble-weighted residue sum of the key
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 8; i++) begin
      sum_next = sum_next + SW'(private_addr[4*i +: 4]) * SW'(RES[i]);
    end
  end

  // Restoring reduction of the sum below BUCKETS
  always_comb begin
    logic [SW-1:0] r;
    r = sum;
    for (int k = 6; k >= 0; k--) begin
      if (r >= (SW'(BUCKETS) << k)) begin
        r = r - (SW'(BUCKETS) << k);
      end
    end
    bucket_next = r[BW-1:0];
  end

  // Way match and first free way
  always_comb begin
    hit_oh    = '0;
    free_oh   = '0;
    any_hit   = 1'b0;
    any_free  = 1'b0;
    hit_entry = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row[w].valid && rd_row[w].key == key_r && !any_hit) begin
        hit_oh[w] = 1'b1;
        any_hit   = 1'b1;
        hit_entry = rd_row[w];
      end
      if (!rd_row[w].valid && !any_free) begin
        free_oh[w] = 1'b1;
        any_free   = 1'b1;
      end
    end
  end

  // Row update and result for the current transaction
  always_comb begin
    wr_row          = rd_row;
    res_status_next = ST_MISS;
    res_public_next = '0;
    res_id_next     = '0;
    if (cmd_r == CMD_LOOKUP) begin
      if (any_hit) begin
        res_status_next = ST_HIT;
        res_public_next = hit_entry.pub;
        res_id_next     = hit_entry.id;
      end
    end else if (any_hit) begin
      if (hit_entry.pub != public_r) begin
        res_status_next = ST_HIT;
      end
      for (int w = 0; w < WAYS; w++) begin
        if (hit_oh[w]) begin
          wr_row[w].pub = public_r;
        end
      end
    end else if (any_free) begin
      res_status_next = ST_HIT;
      for (int w = 0; w < WAYS; w++) begin
        if (free_oh[w]) begin
          wr_row[w] = '{valid: 1'b1, key: key_r, pub: public_r, id: id_r};
        end
      end
    end else begin
      res_status_next = ST_FULL;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_RED;
        end
      end
      S_RED: begin
        state_next = S_RD;
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_EXE;
      end
      S_EXE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          mem_we     = (cmd_r == CMD_REGISTER);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == S_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Transaction and pipeline registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(cmd);
      key_r    <= private_addr;
      public_r <= public_addr;
      id_r     <= echo_id;
      sum      <= sum_next;
    end
    if (state == S_RED) begin
      bucket <= bucket_next;
    end
  end

  // Bucket row memory
  assign mem_waddr = (state == S_CLEAR) ? clr_idx : bucket;
  assign mem_wdata = (state == S_CLEAR) ? '0 : wr_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row <= mem[bucket];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_status <= res_status_next;
      res_public <= res_public_next;
      res_id     <= res_id_next;
    end
  end

  assign status       = res_status;
  assign found_public = res_public;
  assign found_id     = res_id;

  // Checks
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> bucket < BW'(BUCKETS - 1) || bucket == BW'(BUCKETS - 1))
    else $error("bucket index out of range");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_RED)
    else $error("accepted transaction did not start hashing");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EXE)
    else $error("result appeared outside execute step");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HIT |-> found_public == '0 && found_id == '0)
    else $error("nonzero lookup fields without a hit");

endmodule
